### hdl/interval_timer_rate_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// interval timer rate generator assertion macros
// shared concurrent assertion forms, clocked on clk, held off in reset
// ---------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_RATE_GENERATOR_UNIT_ASSERT_SVH
`define INTERVAL_TIMER_RATE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define ITRG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itrg assertion failed");

// next-cycle implication
`define ITRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itrg assertion failed");

`endif

### hdl/itrg_pkg.sv
// ---------------------------------------------------------------------------
// itrg_pkg
// word types and codes of the interval timer rate generator
// ---------------------------------------------------------------------------
package itrg_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] port;
    logic [7:0] wdata;
  } in_word_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } out_word_t;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register offsets
  localparam logic [1:0] PORT_DATA = 2'd0;
  localparam logic [1:0] PORT_CMD  = 2'd3;

  // command fields
  localparam logic [1:0] SEL_CTR0  = 2'b00;
  localparam logic [1:0] ACC_LATCH = 2'b00;

endpackage

### hdl/itrg_core.sv
// ---------------------------------------------------------------------------
// itrg_core
// counter zero state and per-word update logic, mode 2 rate generator
// ---------------------------------------------------------------------------
module itrg_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  itrg_pkg::in_word_t item,
  output itrg_pkg::out_word_t res
);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [COUNT_BITS-1:0] latch_r, latch_nxt;
  logic                  held_r, held_nxt;
  logic                  wr_hi_r, wr_hi_nxt;
  logic                  rd_hi_r, rd_hi_nxt;
  logic                  armed_r, armed_nxt;
  logic                  load_r, load_nxt;

  logic [31:0] reload_w;
  logic [31:0] src_w;
  logic [31:0] lo_w;
  logic [31:0] hi_w;
  logic        is_mode;

  assign reload_w = 32'(reload_r);
  assign src_w    = held_r ? 32'(latch_r) : 32'(count_r);
  assign lo_w     = {reload_w[31:8], item.wdata};
  assign hi_w     = {16'b0, item.wdata, reload_w[7:0]};
  assign is_mode  = (item.op == itrg_pkg::OP_WRITE) && (item.port == itrg_pkg::PORT_CMD) &&
                    (item.wdata[7:6] == itrg_pkg::SEL_CTR0) &&
                    (item.wdata[5:4] != itrg_pkg::ACC_LATCH);

  always_comb begin
    count_nxt  = count_r;
    reload_nxt = reload_r;
    latch_nxt  = latch_r;
    held_nxt   = held_r;
    wr_hi_nxt  = wr_hi_r;
    rd_hi_nxt  = rd_hi_r;
    armed_nxt  = armed_r;
    load_nxt   = load_r;
    res        = '0;
    unique case (item.op)
      itrg_pkg::OP_TICK: begin
        if (armed_r) begin
          if (load_r) begin
            count_nxt = reload_r;
            load_nxt  = 1'b0;
          end else if (count_r == COUNT_BITS'(1)) begin
            count_nxt = reload_r;
            res.irq   = 1'b1;
          end else begin
            count_nxt = count_r - COUNT_BITS'(1);
          end
        end
      end
      itrg_pkg::OP_WRITE: begin
        if (item.port == itrg_pkg::PORT_CMD) begin
          if (item.wdata[7:6] == itrg_pkg::SEL_CTR0) begin
            if (item.wdata[5:4] == itrg_pkg::ACC_LATCH) begin
              if (!held_r) begin
                latch_nxt = count_r;
                held_nxt  = 1'b1;
              end
            end else begin
              armed_nxt = 1'b0;
              load_nxt  = 1'b0;
              held_nxt  = 1'b0;
              wr_hi_nxt = 1'b0;
              rd_hi_nxt = 1'b0;
            end
          end
        end else if (item.port == itrg_pkg::PORT_DATA) begin
          if (!wr_hi_r) begin
            reload_nxt = lo_w[COUNT_BITS-1:0];
            wr_hi_nxt  = 1'b1;
          end else begin
            reload_nxt = hi_w[COUNT_BITS-1:0];
            wr_hi_nxt  = 1'b0;
            if (!armed_r) begin
              armed_nxt = 1'b1;
              load_nxt  = 1'b1;
            end
          end
        end
      end
      itrg_pkg::OP_READ: begin
        if (item.port == itrg_pkg::PORT_DATA) begin
          if (!rd_hi_r) begin
            res.rdata = src_w[7:0];
            rd_hi_nxt = 1'b1;
          end else begin
            res.rdata = src_w[15:8];
            rd_hi_nxt = 1'b0;
            held_nxt  = 1'b0;
          end
        end
      end
      default: begin
        // unused op code: no change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      reload_r <= '0;
      latch_r  <= '0;
      held_r   <= 1'b0;
      wr_hi_r  <= 1'b0;
      rd_hi_r  <= 1'b0;
      armed_r  <= 1'b0;
      load_r   <= 1'b0;
    end else if (fire) begin
      count_r  <= count_nxt;
      reload_r <= reload_nxt;
      latch_r  <= latch_nxt;
      held_r   <= held_nxt;
      wr_hi_r  <= wr_hi_nxt;
      rd_hi_r  <= rd_hi_nxt;
      armed_r  <= armed_nxt;
      load_r   <= load_nxt;
    end
  end

`include "interval_timer_rate_generator_unit_assert.svh"

  `ITRG_ASSERT_NEXT(a_mode_disarms, fire && is_mode, !armed_r && !load_r && !held_r)
  `ITRG_ASSERT_NEXT(a_irq_reloads, fire && res.irq, count_r == $past(reload_r))
  `ITRG_ASSERT_NEXT(a_idle_tick_holds, fire && item.op == itrg_pkg::OP_TICK && !armed_r,
                    $stable(count_r))

endmodule

### hdl/interval_timer_rate_generator_unit.sv
// ---------------------------------------------------------------------------
// interval_timer_rate_generator_unit
// counter zero of an interval timer, rate generator mode, one word per cycle
// ---------------------------------------------------------------------------
// usage:
//   in_word carries one item per word: a clock tick, a bus write (count byte
//   or command) or a bus read. out_word returns exactly one word per input
//   word, in order: rdata for a read of counter zero, irq on the tick where
//   the count reaches terminal count and reloads, zero otherwise.
// path: an accepted word sits in the input register, is applied to the
//   counter state and lands in the result register behind out_valid.
// throughput: 1 word per cycle while out_ready is high; the counter update
//   is a short decrement, compare and byte select between the two registers.
// stall: when out_ready is low the result register holds, the input
//   register holds its word, and in_ready drops once both are full; in_ready
//   follows out_ready combinationally so no cycle is lost on release.
// reset: rst_n low empties both registers and clears all counter state; the
//   counter comes up disarmed with count and reload at zero.
// ---------------------------------------------------------------------------
module interval_timer_rate_generator_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itrg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output itrg_pkg::out_word_t out_word
);

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  itrg_pkg::in_word_t s1_word_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  itrg_pkg::out_word_t out_word_r;

  // core result for the word in the input register
  itrg_pkg::out_word_t core_res;

  logic advance;
  logic in_fire;

  // the input word moves on whenever the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= core_res;
    end
  end

  // counter state commits exactly when its result enters the result register
  itrg_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_word_r),
    .res   (core_res)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "interval_timer_rate_generator_unit_assert.svh"

  // every accepted word reaches the input register
  `ITRG_ASSERT_NEXT(a_in_lands, in_fire, s1_valid_r)
  // a word leaving the input register always shows up as a result
  `ITRG_ASSERT_NEXT(a_out_lands, advance, out_valid_r)
  // irq never comes back for anything but a tick
  `ITRG_ASSERT_SAME(a_irq_tick_only, advance && core_res.irq,
                    s1_word_r.op == itrg_pkg::OP_TICK)

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for counter zero of the interval timer in rate
// generator mode: bus words (ticks, writes, reads) go in through a queue-fed
// driver, every result word is checked field by field against an in-bench
// model of the counter, with random idling on both handshakes
// ---------------------------------------------------------------------------
module tb_top;
  import itrg_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [1:0] PORT_ONE     = 2'd1;
  localparam logic [1:0] PORT_TWO     = 2'd2;
  localparam logic [1:0] SEL_CTR1     = 2'b01;
  localparam logic [1:0] SEL_READBACK = 2'b11;
  localparam logic [1:0] ACC_LSB_MSB  = 2'b11;
  localparam logic [2:0] MODE_RATE    = 3'b010;

  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned LONG_HOLD    = 150;   // receiver hold-off, cycles
  localparam int unsigned HOLD_AT      = 300;   // results seen before it
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    in_word_t word;
    bit       drain;    // sender waits for all replies before offering it
  } bus_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  interval_timer_rate_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // counter model: own copy of the timer state
  // ---------------------------------------------------------------------------
  logic [15:0] live_count;
  logic [15:0] reload_reg;
  logic [15:0] frozen_count;
  bit          frozen;          // latch command holds a snapshot
  bit          write_msb_next;  // byte toggle for data writes
  bit          read_msb_next;   // byte toggle for data reads
  bit          running;         // counter armed
  bit          load_on_tick;    // reload goes in on the next tick

  initial begin
    live_count     = '0;
    reload_reg     = '0;
    frozen_count   = '0;
    frozen         = 1'b0;
    write_msb_next = 1'b0;
    read_msb_next  = 1'b0;
    running        = 1'b0;
    load_on_tick   = 1'b0;
  end

  // applies one bus word to the model and returns the reply it causes
  function automatic out_word_t apply_bus_word(in_word_t w);
    out_word_t   r;
    logic [15:0] src;
    r = '0;
    case (w.op)
      OP_TICK: begin
        if (running) begin
          if (load_on_tick) begin
            live_count   = reload_reg;
            load_on_tick = 1'b0;
          end else if (live_count == 16'd1) begin
            // terminal count: reload and pulse
            live_count = reload_reg;
            r.irq      = 1'b1;
          end else begin
            live_count = live_count - 16'd1;   // zero wraps to all ones
          end
        end
      end
      OP_WRITE: begin
        if (w.port == PORT_CMD) begin
          if (w.wdata[7:6] == SEL_CTR0) begin
            if (w.wdata[5:4] == ACC_LATCH) begin
              // a second latch while one is held is dropped
              if (!frozen) begin
                frozen_count = live_count;
                frozen       = 1'b1;
              end
            end else begin
              // mode write: disarm, drop any latch and reset both toggles
              running        = 1'b0;
              load_on_tick   = 1'b0;
              frozen         = 1'b0;
              write_msb_next = 1'b0;
              read_msb_next  = 1'b0;
            end
          end
        end else if (w.port == PORT_DATA) begin
          if (!write_msb_next) begin
            reload_reg[7:0] = w.wdata;
            write_msb_next  = 1'b1;
          end else begin
            reload_reg[15:8] = w.wdata;
            write_msb_next   = 1'b0;
            // rewrite while armed waits for terminal count
            if (!running) begin
              running      = 1'b1;
              load_on_tick = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (w.port == PORT_DATA) begin
          src = frozen ? frozen_count : live_count;
          if (!read_msb_next) begin
            r.rdata       = src[7:0];
            read_msb_next = 1'b1;
          end else begin
            r.rdata       = src[15:8];
            read_msb_next = 1'b0;
            frozen        = 1'b0;
          end
        end
      end
      default: ;   // unused op changes nothing
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store and reply store
  // ---------------------------------------------------------------------------
  bus_item_t   bus_q[$];     // words still to be offered
  out_word_t   reply_q[$];   // replies predicted, not yet seen
  bit          pause_next;   // marks the next queued word as a drain point
  int unsigned err_cnt;
  int unsigned got_cnt;

  initial begin
    pause_next = 1'b0;
    err_cnt    = 0;
    got_cnt    = 0;
  end

  task automatic put(logic [1:0] op, logic [1:0] port, logic [7:0] data);
    bus_item_t it;
    it.word.op    = op;
    it.word.port  = port;
    it.word.wdata = data;
    it.drain      = pause_next;
    pause_next    = 1'b0;
    bus_q.push_back(it);
  endtask

  task automatic put_ticks(int unsigned n);
    repeat (n) put(OP_TICK, PORT_DATA, 8'($urandom));
  endtask

  // mode write then reload as low byte, high byte
  task automatic put_program(logic [15:0] reload);
    put(OP_WRITE, PORT_CMD,
        {SEL_CTR0, 2'($urandom_range(1, 3)), 4'($urandom)});
    put(OP_WRITE, PORT_DATA, reload[7:0]);
    put(OP_WRITE, PORT_DATA, reload[15:8]);
  endtask

  function automatic logic [15:0] pick_reload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 12));
    if (r < 85) return 16'($urandom_range(13, 300));
    if (r < 95) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0: return 16'h0000;
      1: return 16'h0001;
      default: return 16'hffff;
    endcase
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: sample acceptance at the rising edge, drive at the falling edge
  // ---------------------------------------------------------------------------
  bit          word_taken = 1'b0;
  bit          tx_quiet   = 1'b0;
  int unsigned tx_gap     = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      reply_q.push_back(apply_bus_word(in_word));
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_in
    logic      nv;
    bus_item_t it;
    // keep offering until the word is taken
    nv = in_valid && !word_taken;
    word_taken = 1'b0;
    if (rst_n && !nv) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (bus_q.size() > 0 &&
                   (!bus_q[0].drain || reply_q.size() == 0)) begin
        it = bus_q.pop_front();
        in_word <= it.word;
        nv = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_gap = idle_len(tx_quiet);
      end
    end
    in_valid <= nv;
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, one long hold-off to back up the input side
  // ---------------------------------------------------------------------------
  bit          rx_quiet     = 1'b0;
  bit          long_hold_on = 1'b0;
  int unsigned rx_gap       = 0;
  int unsigned rx_hold      = 0;

  always @(negedge clk) begin : drive_out_ready
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (rx_hold > 0) begin
        rx_hold--;
      end else if (!long_hold_on && got_cnt >= HOLD_AT) begin
        long_hold_on = 1'b1;
        rx_hold      = LONG_HOLD;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_gap = idle_len(rx_quiet);
      end
    end
    out_ready <= rdy;
  end

  // monitor: each result word against the oldest prediction
  always @(posedge clk) begin : check_out
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (reply_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result word with none expected: rdata=%02h irq=%b",
                 $time, out_word.rdata, out_word.irq);
      end else begin
        want = reply_q.pop_front();
        if (out_word.rdata !== want.rdata) begin
          err_cnt++;
          $display("%0t: rdata mismatch: expected %02h, actual %02h",
                   $time, want.rdata, out_word.rdata);
        end
        if (out_word.irq !== want.irq) begin
          err_cnt++;
          $display("%0t: irq mismatch: expected %b, actual %b",
                   $time, want.irq, out_word.irq);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin : plan
    int unsigned r;
    int unsigned target;

    // directed: reads straight out of reset, live count of zero
    put(OP_READ, PORT_DATA, 8'h00);
    put(OP_READ, PORT_DATA, 8'hff);
    put(OP_READ, PORT_CMD, 8'h00);
    // disarmed tick, unused op, writes to unused ports
    put(OP_TICK, PORT_DATA, 8'h00);
    put(OP_UNUSED, PORT_CMD, 8'hff);
    put(OP_WRITE, PORT_ONE, 8'hff);
    put(OP_WRITE, PORT_TWO, 8'h00);
    // commands for another counter and read-back are dropped
    put(OP_WRITE, PORT_CMD, {SEL_CTR1, ACC_LSB_MSB, MODE_RATE, 1'b0});
    put(OP_WRITE, PORT_CMD, {SEL_READBACK, 6'h3f});
    // reload of one: low byte alone leaves it disarmed, then irq every tick after the load
    put(OP_WRITE, PORT_CMD, {SEL_CTR0, ACC_LSB_MSB, MODE_RATE, 1'b0});
    put(OP_WRITE, PORT_DATA, 8'h01);
    put(OP_TICK, PORT_DATA, 8'h00);
    put(OP_WRITE, PORT_DATA, 8'h00);
    put(OP_TICK, PORT_DATA, 8'h00);
    put(OP_TICK, PORT_DATA, 8'h00);
    // double latch, then both bytes of the snapshot
    put(OP_WRITE, PORT_CMD, {SEL_CTR0, ACC_LATCH, 4'h0});
    put(OP_WRITE, PORT_CMD, {SEL_CTR0, ACC_LATCH, 4'hf});
    put(OP_READ, PORT_DATA, 8'h00);
    put(OP_READ, PORT_DATA, 8'h00);
    // reload rewritten while armed lands at terminal count
    put(OP_WRITE, PORT_DATA, 8'hff);
    put(OP_WRITE, PORT_DATA, 8'hff);
    put(OP_TICK, PORT_DATA, 8'hff);
    // reload of zero: count wraps to all ones
    put_program(16'h0000);
    put_ticks(2);
    put(OP_READ, PORT_DATA, 8'h00);
    put(OP_READ, PORT_DATA, 8'h00);

    // sender waits here for every reply
    pause_next = 1'b1;
    target = bus_q.size() + RANDOM_WORDS;
    while (bus_q.size() < target) begin
      if (bus_q.size() > target / 2 && bus_q.size() < target / 2 + 4)
        pause_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        put_program(pick_reload());
      end else if (r < 22) begin
        // new reload while running
        put(OP_WRITE, PORT_DATA, 8'($urandom));
        put(OP_WRITE, PORT_DATA, 8'($urandom));
      end else if (r < 55) begin
        put_ticks($urandom_range(1, 24));
      end else if (r < 75) begin
        put(OP_WRITE, PORT_CMD, {SEL_CTR0, ACC_LATCH, 4'($urandom)});
        if ($urandom_range(0, 3) == 0) put_ticks($urandom_range(1, 3));
        if ($urandom_range(0, 4) == 0)
          put(OP_WRITE, PORT_CMD, {SEL_CTR0, ACC_LATCH, 4'($urandom)});
        put(OP_READ, PORT_DATA, 8'($urandom));
        put(OP_READ, PORT_DATA, 8'($urandom));
      end else if (r < 82) begin
        // live count without a latch
        repeat ($urandom_range(1, 2)) put(OP_READ, PORT_DATA, 8'($urandom));
      end else if (r < 87) begin
        // low byte only
        put(OP_WRITE, PORT_DATA, 8'($urandom));
        put_ticks($urandom_range(1, 4));
      end else begin
        // noise over the whole field range
        repeat ($urandom_range(1, 4))
          put(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)));
      end
    end

    // all words taken, all replies back, then let the pipe settle
    while (bus_q.size() != 0 || in_valid || reply_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
